### design/sfp_pkg.sv
// Shared types and constants for the sync frame target parser.
// No dependencies; imported by sfp_frame_fsm, sync_frame_target_parser and tb_top.
package sfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND = 8'h5A;

  typedef enum logic [6:0] {
    PH_HUNT  = 7'b0000001,
    PH_SYNC2 = 7'b0000010,
    PH_X     = 7'b0000100,
    PH_Y     = 7'b0001000,
    PH_DHI   = 7'b0010000,
    PH_DLO   = 7'b0100000,
    PH_CHECK = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [9:0]  x_coord;
    logic [9:0]  y_coord;
    logic [15:0] distance;
  } sfp_result_t;

  typedef struct packed {
    logic        valid;
    sfp_result_t data;
  } sfp_emit_t;

  typedef struct packed {
    logic at_check;
  } sfp_status_t;

endpackage

### design/sfp_frame_fsm.sv
// Frame phase tracker: sync hunt, byte capture and checksum compare.
// Depends on sfp_pkg; instantiated by sync_frame_target_parser.
module sfp_frame_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_accept,
  input  logic [7:0]         rx_byte,
  output sfp_pkg::sfp_emit_t   emit,
  output sfp_pkg::sfp_status_t status
);
  import sfp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] x_byte_r, y_byte_r, dist_high_r, dist_low_r;
  logic [7:0] sum;

  assign sum = x_byte_r + y_byte_r;

  always_comb begin
    phase_nxt = PH_HUNT;
    case (phase_r)
      PH_HUNT:  phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      PH_SYNC2: phase_nxt = (rx_byte == SYNC_SECOND) ? PH_X : PH_HUNT;
      PH_X:     phase_nxt = PH_Y;
      PH_Y:     phase_nxt = PH_DHI;
      PH_DHI:   phase_nxt = PH_DLO;
      PH_DLO:   phase_nxt = PH_CHECK;
      PH_CHECK: phase_nxt = PH_HUNT;
      default:  phase_nxt = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else if (byte_accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      if (phase_r == PH_X)   x_byte_r    <= rx_byte;
      if (phase_r == PH_Y)   y_byte_r    <= rx_byte;
      if (phase_r == PH_DHI) dist_high_r <= rx_byte;
      if (phase_r == PH_DLO) dist_low_r  <= rx_byte;
    end
  end

  // times three as shift plus add
  assign emit.valid         = byte_accept && (phase_r == PH_CHECK) && (sum == rx_byte);
  assign emit.data.x_coord  = {1'b0, x_byte_r, 1'b0} + {2'b00, x_byte_r};
  assign emit.data.y_coord  = {1'b0, y_byte_r, 1'b0} + {2'b00, y_byte_r};
  assign emit.data.distance = {dist_high_r, dist_low_r};
  assign status.at_check    = (phase_r == PH_CHECK);

endmodule

### design/sync_frame_target_parser.sv
// Top level of the sync frame target parser: phase tracker plus result register.
// Depends on sfp_pkg and sfp_frame_fsm.
//
// Usage:
//   Input channel in_valid/in_ready/in_rx_byte carries one serial byte per item.
//   Frames are A5 5A x y dist_hi dist_lo check; check must equal x+y mod 256.
//   Result channel out_valid/out_ready carries out_x_coord (x*3), out_y_coord
//   (y*3) and out_distance; a bad checksum yields no result item.
//   Throughput: one byte per cycle unless a check byte stalls. Latency: the result is valid in the cycle
//   after the check byte is accepted, from a single output register.
//   Stall: while a result waits, bytes of the next frame are still taken; only
//   a check byte waits for the output register to free up (in_ready tracks
//   out_ready in that phase, combinationally).
//   Reset (rst_n low, synchronous): parser returns to hunting the first sync
//   byte and any pending result is dropped.
module sync_frame_target_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_x_coord,
  output logic [9:0]  out_y_coord,
  output logic [15:0] out_distance
);
  import sfp_pkg::*;

  sfp_emit_t   emit;
  sfp_status_t status;
  logic        out_valid_r;
  sfp_result_t out_data_r;

  assign in_ready = !status.at_check || !out_valid_r || out_ready;

  sfp_frame_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_valid && in_ready),
    .rx_byte     (in_rx_byte),
    .emit        (emit),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) out_data_r <= emit.data;
  end

  assign out_valid    = out_valid_r;
  assign out_x_coord  = out_data_r.x_coord;
  assign out_y_coord  = out_data_r.y_coord;
  assign out_distance = out_data_r.distance;

endmodule

### design/sfp_checker.sv
// Port-level assertions for sync_frame_target_parser, attached by bind.
// Depends only on the top level's ports.
module sfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  out_x_coord,
  input logic [9:0]  out_y_coord,
  input logic [15:0] out_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_coord)
      && $stable(out_y_coord) && $stable(out_distance))
    else $error("stalled result changed");

  a_new_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted item");

  a_next_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid || $past(in_valid && in_ready))
    else $error("result repeated after delivery");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x_coord <= 10'd765 && out_y_coord <= 10'd765)
    else $error("coordinate out of range");

endmodule

bind sync_frame_target_parser sfp_checker u_sfp_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for sync_frame_target_parser: byte stream in, target frames out.
// Depends on sfp_pkg and the RTL; holds its own frame predictor and a result scoreboard.
module tb_top;
  import sfp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  out_x_coord;
  logic [9:0]  out_y_coord;
  logic [15:0] out_distance;

  sfp_result_t frames_due[$];
  phase_t      prd_phase;
  logic [7:0]  prd_x;
  logic [7:0]  prd_y;
  logic [7:0]  prd_dhi;
  logic [7:0]  prd_dlo;

  int  n_errors;
  int  n_bytes;
  int  n_frames;
  bit  gaps_on;
  bit  stalls_on;

  sync_frame_target_parser i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x_coord  (out_x_coord),
    .out_y_coord  (out_y_coord),
    .out_distance (out_distance)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit parse_byte(input logic [7:0] b, output sfp_result_t frame);
    logic [7:0] sum;
    bit         hit;
    hit   = 1'b0;
    frame = '0;
    sum   = prd_x + prd_y;
    case (prd_phase)
      PH_HUNT: begin
        if (b == SYNC_FIRST) prd_phase = PH_SYNC2;
        else prd_phase = PH_HUNT;
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) prd_phase = PH_X;
        else prd_phase = PH_HUNT;
      end
      PH_X: begin
        prd_x     = b;
        prd_phase = PH_Y;
      end
      PH_Y: begin
        prd_y     = b;
        prd_phase = PH_DHI;
      end
      PH_DHI: begin
        prd_dhi   = b;
        prd_phase = PH_DLO;
      end
      PH_DLO: begin
        prd_dlo   = b;
        prd_phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (sum == b) begin
          frame.x_coord  = {2'b00, prd_x} * 10'd3;
          frame.y_coord  = {2'b00, prd_y} * 10'd3;
          frame.distance = {prd_dhi, prd_dlo};
          hit            = 1'b1;
        end
        prd_phase = PH_HUNT;
      end
      default: prd_phase = PH_HUNT;
    endcase
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin : scoreboard
    sfp_result_t want;
    sfp_result_t nxt;
    if (!rst_n) begin
      prd_phase = PH_HUNT;
      prd_x     = '0;
      prd_y     = '0;
      prd_dhi   = '0;
      prd_dlo   = '0;
      frames_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        n_frames++;
        if (frames_due.size() == 0) begin
          report_mismatch("unexpected frame, x_coord", int'(out_x_coord), -1);
        end else begin
          want = frames_due.pop_front();
          if (out_x_coord != want.x_coord)
            report_mismatch("x_coord", int'(out_x_coord), int'(want.x_coord));
          if (out_y_coord != want.y_coord)
            report_mismatch("y_coord", int'(out_y_coord), int'(want.y_coord));
          if (out_distance != want.distance)
            report_mismatch("distance", int'(out_distance), int'(want.distance));
        end
      end
      if (in_valid && in_ready) begin
        if (parse_byte(in_rx_byte, nxt)) frames_due.push_back(nxt);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_bytes++;
  endtask

  task automatic send_frame(input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] dhi, input logic [7:0] dlo, input bit good);
    logic [7:0] chk;
    chk = x + y;
    if (!good) chk = chk + 8'($urandom_range(1, 255));
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(x);
    send_byte(y);
    send_byte(dhi);
    send_byte(dlo);
    send_byte(chk);
  endtask

  task automatic test_field_extremes();
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
  endtask

  // repeated first sync must not count as a fresh first sync
  task automatic test_bad_second_sync();
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
  endtask

  task automatic test_bad_checksum();
    send_frame(8'h01, 8'h02, 8'h12, 8'h34, 1'b0);
  endtask

  task automatic send_random_chunk();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    end else if (kind == 7) begin
      send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    end else if (kind == 8) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) send_byte(SYNC_FIRST);
        else send_byte(8'($urandom));
      end
    end else begin
      send_byte(SYNC_FIRST);
      n = $urandom_range(0, 5);
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) send_byte(SYNC_FIRST);
        else send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_random_stream();
    while (n_bytes < 1250) send_random_chunk();
  endtask

  task automatic test_back_to_back();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (n_bytes < 1450) send_random_chunk();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    n_errors   = 0;
    n_bytes    = 0;
    n_frames   = 0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_bad_second_sync();
    test_bad_checksum();
    test_random_stream();
    test_back_to_back();

    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes (good, bad-checksum, broken-sync and noise), checked %0d frames",
             n_bytes, n_frames);
    $display("input gaps and output stalls, then a back-to-back stretch");
    if (n_errors == 0) $display("[sync_frame_target_parser] OK");
    else $display("[sync_frame_target_parser] ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("[sync_frame_target_parser] ERROR");
    $finish;
  end

endmodule

### sync_frame_target_parser.f
design/sfp_pkg.sv
design/sfp_frame_fsm.sv
design/sync_frame_target_parser.sv
design/sfp_checker.sv
tb/tb_top.sv
